[src/jfs_pkg.sv]
// jfs_pkg: word types, control struct and fixed field widths for the
// Johnson's-rule flow-shop sequencer. No dependencies.
package jfs_pkg;

    localparam int ID_W        = 6;
    localparam int IN_TIME_W   = 16;
    localparam int FIRST_OUT_W = 22;
    localparam int SECOND_OUT_W = 23;

    typedef struct packed {
        logic [ID_W-1:0]      job_id;
        logic [IN_TIME_W-1:0] time_first;
        logic [IN_TIME_W-1:0] time_second;
        logic                 last_job;
    } job_t;

    typedef struct packed {
        logic [ID_W-1:0]         sched_job_id;
        logic [FIRST_OUT_W-1:0]  first_done_time;
        logic [SECOND_OUT_W-1:0] second_done_time;
        logic                    last_result;
        logic                    overflowed;
    } result_t;

    // chain control broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift;
    } ctl_t;

endpackage

[src/jfs_cell.sv]
// jfs_cell: one slot of the sorted insertion chain.
// Depends on jfs_pkg (ctl_t, ID_W).
module jfs_cell #(
    parameter int TIME_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  jfs_pkg::ctl_t            ctl,
    input  logic [jfs_pkg::ID_W-1:0] new_id,
    input  logic [TIME_BITS-1:0]     new_t1,
    input  logic [TIME_BITS-1:0]     new_t2,
    input  logic                     prev_valid,
    input  logic [jfs_pkg::ID_W-1:0] prev_id,
    input  logic [TIME_BITS-1:0]     prev_t1,
    input  logic [TIME_BITS-1:0]     prev_t2,
    input  logic                     prev_before,
    input  logic                     next_valid,
    input  logic [jfs_pkg::ID_W-1:0] next_id,
    input  logic [TIME_BITS-1:0]     next_t1,
    input  logic [TIME_BITS-1:0]     next_t2,
    output logic                     valid,
    output logic [jfs_pkg::ID_W-1:0] id,
    output logic [TIME_BITS-1:0]     t1,
    output logic [TIME_BITS-1:0]     t2,
    output logic                     ahead
);
    import jfs_pkg::*;

    logic                 valid_reg, valid_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [TIME_BITS-1:0] t1_reg, t1_next;
    logic [TIME_BITS-1:0] t2_reg, t2_next;
    logic                 new_a, my_a, goes_first;

    // strict Johnson order: ties leave the new word behind the stored one
    always_comb
    begin
        new_a = (new_t1 <= new_t2);
        my_a  = (t1_reg <= t2_reg);
        if (new_a != my_a)
        begin
            goes_first = new_a;
        end
        else if (new_a)
        begin
            goes_first = (new_t1 < t1_reg);
        end
        else
        begin
            goes_first = (new_t2 > t2_reg);
        end
    end

    assign ahead = !valid_reg || goes_first;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        t1_next    = t1_reg;
        t2_next    = t2_reg;
        if (ctl.shift)
        begin
            valid_next = next_valid;
            id_next    = next_id;
            t1_next    = next_t1;
            t2_next    = next_t2;
        end
        else if (ctl.insert && ahead)
        begin
            if (prev_before)
            begin
                valid_next = prev_valid;
                id_next    = prev_id;
                t1_next    = prev_t1;
                t2_next    = prev_t2;
            end
            else
            begin
                valid_next = 1'b1;
                id_next    = new_id;
                t1_next    = new_t1;
                t2_next    = new_t2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
        t1_reg <= t1_next;
        t2_reg <= t2_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign t1    = t1_reg;
    assign t2    = t2_reg;

endmodule

[src/johnson_flow_shop_sequencer.sv]
// johnson_flow_shop_sequencer: top level; insertion chain of jfs_cell plus
// the completion-time accumulator. Depends on jfs_pkg and jfs_cell.
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+-----------------------------------
//  job in   | job (job_t)                   | taken when start & !busy
//  result   | result (result_t)             | result_valid strobe, one cycle
//
// Loading takes one job word per cycle while busy is low; the chain sorts on insertion.
// A word with last_job starts emission: busy stays high until the chain is empty,
// one chain cell popped per cycle, each result registered and strobed in the cycle
// after its pop. A new set may start in the cycle of the final result.
// Reset clears the chain valid bits, the accumulators and the drop flag.
// The receiver cannot stall; results are never held.
module johnson_flow_shop_sequencer #(
    parameter int MAX_JOBS  = 64,
    parameter int TIME_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  jfs_pkg::job_t    job,
    output logic             result_valid,
    output jfs_pkg::result_t result
);
    import jfs_pkg::*;

    localparam int FW = TIME_BITS + $clog2(MAX_JOBS);
    localparam int SW = FW + 1;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t  state_reg, state_next;
    logic    drop_reg, drop_next;
    logic [FW-1:0] f_reg, f_next;
    logic [SW-1:0] s_reg, s_next;
    logic    rv_reg, rv_next;
    result_t res_reg, res_next;

    ctl_t ctl;
    logic accept, full;
    logic [TIME_BITS-1:0] new_t1, new_t2;
    logic [TIME_BITS+IN_TIME_W-1:0] t1_ext, t2_ext;

    logic                 c_valid  [MAX_JOBS];
    logic [ID_W-1:0]      c_id     [MAX_JOBS];
    logic [TIME_BITS-1:0] c_t1     [MAX_JOBS];
    logic [TIME_BITS-1:0] c_t2     [MAX_JOBS];
    logic                 c_before [MAX_JOBS];
    logic [MAX_JOBS-1:0]  valid_vec;

    logic [FW-1:0] f_sum;
    logic [SW-1:0] s_max, s_sum;
    logic [FW+FIRST_OUT_W-1:0]  f_out_ext;
    logic [SW+SECOND_OUT_W-1:0] s_out_ext;
    logic pop_last;

    // times are taken in their low TIME_BITS bits
    assign t1_ext = {{TIME_BITS{1'b0}}, job.time_first};
    assign t2_ext = {{TIME_BITS{1'b0}}, job.time_second};
    assign new_t1 = t1_ext[TIME_BITS-1:0];
    assign new_t2 = t2_ext[TIME_BITS-1:0];

    assign busy   = (state_reg == ST_EMIT);
    assign accept = start && !busy;
    assign full   = c_valid[MAX_JOBS-1];
    // {insert, shift}
    assign ctl    = {accept && !full, busy};

    for (genvar g = 0; g < MAX_JOBS; g++)
    begin : g_chain
        logic                 p_valid, p_before, n_valid;
        logic [ID_W-1:0]      p_id, n_id;
        logic [TIME_BITS-1:0] p_t1, p_t2, n_t1, n_t2;

        if (g == 0)
        begin : g_head
            assign p_valid  = 1'b0;
            assign p_id     = '0;
            assign p_t1     = '0;
            assign p_t2     = '0;
            assign p_before = 1'b0;
        end
        else
        begin : g_body
            assign p_valid  = c_valid[g-1];
            assign p_id     = c_id[g-1];
            assign p_t1     = c_t1[g-1];
            assign p_t2     = c_t2[g-1];
            assign p_before = c_before[g-1];
        end

        if (g == MAX_JOBS-1)
        begin : g_tail
            assign n_valid = 1'b0;
            assign n_id    = '0;
            assign n_t1    = '0;
            assign n_t2    = '0;
        end
        else
        begin : g_link
            assign n_valid = c_valid[g+1];
            assign n_id    = c_id[g+1];
            assign n_t1    = c_t1[g+1];
            assign n_t2    = c_t2[g+1];
        end

        jfs_cell #(.TIME_BITS(TIME_BITS)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_id      (job.job_id),
            .new_t1      (new_t1),
            .new_t2      (new_t2),
            .prev_valid  (p_valid),
            .prev_id     (p_id),
            .prev_t1     (p_t1),
            .prev_t2     (p_t2),
            .prev_before (p_before),
            .next_valid  (n_valid),
            .next_id     (n_id),
            .next_t1     (n_t1),
            .next_t2     (n_t2),
            .valid       (c_valid[g]),
            .id          (c_id[g]),
            .t1          (c_t1[g]),
            .t2          (c_t2[g]),
            .ahead       (c_before[g])
        );

        assign valid_vec[g] = c_valid[g];
    end

    // completion times for the head cell
    assign f_sum = f_reg + FW'(c_t1[0]);
    assign s_max = (SW'(f_sum) > s_reg) ? SW'(f_sum) : s_reg;
    assign s_sum = s_max + SW'(c_t2[0]);
    assign f_out_ext = {{FIRST_OUT_W{1'b0}}, f_sum};
    assign s_out_ext = {{SECOND_OUT_W{1'b0}}, s_sum};
    assign pop_last  = !c_valid[1];

    always_comb
    begin
        state_next = state_reg;
        drop_next  = drop_reg;
        f_next     = f_reg;
        s_next     = s_reg;
        rv_next    = 1'b0;
        res_next   = res_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    if (job.last_job)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                rv_next                   = 1'b1;
                res_next.sched_job_id     = c_id[0];
                res_next.first_done_time  = f_out_ext[FIRST_OUT_W-1:0];
                res_next.second_done_time = s_out_ext[SECOND_OUT_W-1:0];
                res_next.last_result      = pop_last;
                res_next.overflowed       = drop_reg;
                f_next = f_sum;
                s_next = s_sum;
                if (pop_last)
                begin
                    state_next = ST_LOAD;
                    drop_next  = 1'b0;
                    f_next     = '0;
                    s_next     = '0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            drop_reg  <= 1'b0;
            f_reg     <= '0;
            s_reg     <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drop_reg  <= drop_next;
            f_reg     <= f_next;
            s_reg     <= s_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

    // occupied cells always form a prefix of the chain
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec & (valid_vec + 1'b1)) == '0))
        else $error("chain occupancy is not a prefix");

    a_emit_head: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> c_valid[0])
        else $error("emitting from an empty chain");

    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without a pop");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_result) |-> (!busy && !c_valid[0]))
        else $error("chain not empty after the final result");

    a_accum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (f_reg == '0 && s_reg == '0))
        else $error("accumulators not cleared between sets");

endmodule
